>>> sv/jimj_pkg.sv
//------------------------------------------------------------------------------
// jimj_pkg: shared types and constants
// Widths, fixed-point constants and the front-to-back command word.
//------------------------------------------------------------------------------
`default_nettype none

package jimj_pkg;

    localparam int JOINTS_DEF      = 7;
    localparam int ANGLE_WIDTH_DEF = 20;
    localparam int GAIN_W          = 9;
    localparam int PACKED_W        = 63;
    localparam int DUR_W           = 24;
    localparam int THR_W           = 19;
    localparam int TIME_W          = 32;
    localparam int PERIOD_W        = 16;
    localparam int TORQUE_W        = 24;
    localparam int JIDX_W          = 3;
    localparam int MODE_W          = 2;

    localparam logic [11:0] CLOSE_LIMIT = 12'd3277;
    localparam logic [9:0]  FILT_OLD    = 10'd655;
    localparam logic [15:0] FILT_NEW    = 16'd64881;

    localparam logic [2:0] REG_STIFF = 3'd0;
    localparam logic [2:0] REG_DAMP  = 3'd1;
    localparam logic [2:0] REG_FIRST = 3'd2;
    localparam logic [2:0] REG_SAFE  = 3'd3;
    localparam logic [2:0] REG_THR   = 3'd4;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TARGET = 1'b1;

    localparam logic [1:0] MODE_HOLD   = 2'd0;
    localparam logic [1:0] MODE_FIRST  = 2'd1;
    localparam logic [1:0] MODE_SAFE   = 2'd2;
    localparam logic [1:0] MODE_DIRECT = 2'd3;

    // one classified input word handed from front to back
    typedef struct packed {
        logic                   op;
        logic [JIDX_W-1:0]      joint;
        logic [31:0]            position;   // widest allowed angle, sign extended
        logic [31:0]            velocity;
        logic [PERIOD_W-1:0]    period;
        logic                   closing;    // last joint of the set
    } cmd_t;

endpackage : jimj_pkg

`default_nettype wire

>>> sv/joint_impedance_min_jerk_controller_core.sv
//------------------------------------------------------------------------------
// joint_impedance_min_jerk_controller_core: joint impedance torque controller
// Per-joint samples and targets in, seven saturated torque words out.
//------------------------------------------------------------------------------
// Usage:
//  s_axis: one word per joint. tuser = op (0 sample, 1 target). tdata packs
//   joint_index, position, velocity and period_us. Words for joints past the
//   last are dropped. Only a joint 6 sample produces output.
//  m_axis: seven words per closing sample, joint 0 first, tlast on joint 6;
//   tuser carries the mode.
//  cfg: index/data write port; the user must write it only while the block is idle (not enforced).
// Flow: a front FIFO of four words takes inputs at one per
//  cycle while the back is busy, until it is full. A non-closing word is
//  applied on acceptance; a target commit adds a seven-joint scan; a closing
//  sample adds a scan and a goal decision, plus the divider and the polynomial
//  steps when an approach is active, then each joint passes in turn through
//  the shared multiply pipeline before its torque word is emitted.
// Reset: gains zero, durations and threshold at defaults, joint state and flags clear.
// A stalled m_axis holds the current word; the back waits, the FIFO fills
//  and then s_axis_tready drops.
//------------------------------------------------------------------------------
`default_nettype none

module joint_impedance_min_jerk_controller_core #(
    parameter int JOINTS      = jimj_pkg::JOINTS_DEF,
    parameter int ANGLE_WIDTH = jimj_pkg::ANGLE_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] joint_index, [22:3] position, [42:23] velocity, [58:43] period_us
    // (offsets shown for 20-bit angles)
    input  wire logic [((2*ANGLE_WIDTH+26)/8)*8-1:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] joint_number, [26:3] torque
    output logic [31:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // mode
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [62:0] cfg_data
);

    logic [62:0] stiff_reg, damp_reg;
    logic [23:0] first_reg, safe_reg;
    logic [18:0] thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiff_reg <= '0;
            damp_reg  <= '0;
            first_reg <= 24'd3000000;
            safe_reg  <= 24'd2000000;
            thr_reg   <= 19'd32768;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                jimj_pkg::REG_STIFF: stiff_reg <= cfg_data;
                jimj_pkg::REG_DAMP:  damp_reg  <= cfg_data;
                jimj_pkg::REG_FIRST: first_reg <= cfg_data[23:0];
                jimj_pkg::REG_SAFE:  safe_reg  <= cfg_data[23:0];
                jimj_pkg::REG_THR:   thr_reg   <= cfg_data[18:0];
                default: ;
            endcase
        end
    end

    logic           cmd_valid, cmd_ready;
    jimj_pkg::cmd_t cmd;
    logic [2:0]     o_joint;
    logic [23:0]    o_torque;

    jimj_front #(.JOINTS(JOINTS), .ANGLE_WIDTH(ANGLE_WIDTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .in_joint (s_axis_tdata[2:0]),
        .in_pos   (s_axis_tdata[3 +: ANGLE_WIDTH]),
        .in_vel   (s_axis_tdata[3 + ANGLE_WIDTH +: ANGLE_WIDTH]),
        .in_period(s_axis_tdata[3 + 2*ANGLE_WIDTH +: 16]),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd)
    );

    jimj_back #(.JOINTS(JOINTS), .ANGLE_WIDTH(ANGLE_WIDTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .stiff     (stiff_reg),
        .damp      (damp_reg),
        .first_us  (first_reg),
        .safe_us   (safe_reg),
        .far_thr   (thr_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_joint (o_joint),
        .out_torque(o_torque),
        .out_mode  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, o_torque, o_joint};

endmodule : joint_impedance_min_jerk_controller_core

`default_nettype wire

>>> sv/jimj_front.sv
//------------------------------------------------------------------------------
// jimj_front: input classifier and command queue
// Drops words for out-of-range joints, marks set closers, buffers in a FIFO.
//------------------------------------------------------------------------------
`default_nettype none

module jimj_front #(
    parameter int JOINTS      = jimj_pkg::JOINTS_DEF,
    parameter int ANGLE_WIDTH = jimj_pkg::ANGLE_WIDTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     in_op,
    input  wire logic [2:0]               in_joint,
    input  wire logic [ANGLE_WIDTH-1:0]   in_pos,
    input  wire logic [ANGLE_WIDTH-1:0]   in_vel,
    input  wire logic [15:0]              in_period,
    output logic                          cmd_valid,
    input  wire logic                     cmd_ready,
    output jimj_pkg::cmd_t                cmd
);

    localparam int DEPTH = 4;

    jimj_pkg::cmd_t  fifo_mem [DEPTH];
    logic [1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [2:0]      count_reg;
    jimj_pkg::cmd_t  new_cmd;
    logic            keep, push, pop;

    always_comb begin
        new_cmd.op       = in_op;
        new_cmd.joint    = in_joint;
        new_cmd.position = 32'(signed'(in_pos));
        new_cmd.velocity = 32'(signed'(in_vel));
        new_cmd.period   = in_period;
        new_cmd.closing  = (32'(in_joint) == JOINTS - 1);
    end

    assign keep      = (32'(in_joint) < JOINTS);
    assign in_ready  = (count_reg != 3'(DEPTH));
    assign push      = in_valid && in_ready && keep;
    assign cmd_valid = (count_reg != 3'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = fifo_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= new_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + 3'(push) - 3'(pop);
        end
    end

endmodule : jimj_front

`default_nettype wire

>>> sv/jimj_divider.sv
//------------------------------------------------------------------------------
// jimj_divider: radix-2 restoring divider
// Computes floor(t*2^16/dur), t <= dur, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module jimj_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [23:0] num,     // t, already clamped to dur
    input  wire logic [23:0] den,
    output logic             done,
    output logic [16:0]      quot
);

    logic [24:0] rem_reg, rem_next;
    logic [16:0] q_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [24:0] trial;

    assign trial = {rem_reg[23:0], 1'b0};
    assign quot  = q_reg;

    always_comb begin
        rem_next = trial;
        if (trial >= {1'b0, den}) rem_next = trial - {1'b0, den};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd17;
                // first bit: num >= den gives s = 1.0
                rem_reg  <= {1'b0, num};
                q_reg    <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == 5'd17) begin
                    // integer bit
                    if (num >= den) begin
                        q_reg   <= 17'h10000;
                        rem_reg <= {1'b0, num - den};
                    end
                    cnt_reg <= 5'd16;
                end else begin
                    q_reg   <= q_reg | (17'(trial >= {1'b0, den}) << (cnt_reg - 5'd1));
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1) begin
                        busy_reg <= 1'b0;
                        done     <= 1'b1;
                    end
                end
            end
        end
    end

endmodule : jimj_divider

`default_nettype wire

>>> sv/jimj_back.sv
//------------------------------------------------------------------------------
// jimj_back: control sequencer
// Applies samples and targets, picks goals, filters velocity, emits torques
// one joint per pass through a shared multiply pipeline.
//------------------------------------------------------------------------------
`default_nettype none

module jimj_back #(
    parameter int JOINTS      = jimj_pkg::JOINTS_DEF,
    parameter int ANGLE_WIDTH = jimj_pkg::ANGLE_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire jimj_pkg::cmd_t        cmd,
    input  wire logic [62:0]           stiff,
    input  wire logic [62:0]           damp,
    input  wire logic [23:0]           first_us,
    input  wire logic [23:0]           safe_us,
    input  wire logic [18:0]           far_thr,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [2:0]                 out_joint,
    output logic [23:0]                out_torque,
    output logic [1:0]                 out_mode,
    output logic                       out_last
);

    localparam int JW = $clog2(JOINTS + 1);
    localparam int AW = ANGLE_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE, S_TSCAN, S_SSCAN, S_DECIDE, S_DIVST, S_DIVWT,
        S_P1, S_P2, S_P3, S_JOINT, S_G1, S_G2, S_TQ1, S_TQ2, S_OUT
    } state_t;

    state_t state_reg;

    logic signed [AW-1:0] q_mem   [JOINTS];
    logic signed [AW-1:0] v_mem   [JOINTS];
    logic signed [AW-1:0] f_mem   [JOINTS];
    logic signed [AW-1:0] st_mem  [JOINTS];
    logic signed [AW-1:0] stg_mem [JOINTS];
    logic signed [AW-1:0] tg_mem  [JOINTS];
    logic signed [AW-1:0] org_mem [JOINTS];

    logic [31:0] elapsed_reg, safe_start_reg;
    logic        tvalid_reg, first_reg, safe_reg, farp_reg, captured_reg;
    logic [JW-1:0] idx_reg;
    logic [AW:0]   maxerr_reg;
    logic [1:0]    mode_reg;
    logic          from_origin_reg;
    logic [23:0]   dur_reg, tnum_reg;
    logic [16:0]   s_reg;
    logic [16:0]   s2_reg, s3_reg;    // both at most 1.0 in Q16
    logic [19:0]   inner_reg;
    logic [31:0]   poly_reg;
    logic signed [AW+1:0]  diff_reg;
    logic signed [AW+33:0] prod_reg;
    logic signed [AW+1:0]  goal_reg;
    logic signed [47:0]    ktrm_reg, dtrm_reg;
    logic signed [AW-1:0]  fnew_reg;
    logic                  div_start;
    logic                  div_done;
    logic [16:0]           div_q;

    logic [2:0] jn;
    assign jn = 3'(idx_reg);

    // current-joint reads
    logic signed [AW-1:0] qj, tj, fromj;
    logic signed [AW:0]   dj;
    logic [AW:0]          adj;
    assign qj    = q_mem[idx_reg[JW-1:0] < JW'(JOINTS) ? idx_reg : '0];
    assign tj    = tg_mem[idx_reg < JW'(JOINTS) ? idx_reg : '0];
    assign fromj = from_origin_reg ? org_mem[idx_reg < JW'(JOINTS) ? idx_reg : '0]
                                   : st_mem[idx_reg < JW'(JOINTS) ? idx_reg : '0];
    assign dj    = (AW+1)'(tj) - (AW+1)'(qj);
    assign adj   = dj[AW] ? (AW+1)'(-dj) : (AW+1)'(dj);

    logic [31:0] elapsed_sum;
    logic [32:0] esum;
    assign esum        = {1'b0, elapsed_reg} + 33'(cmd.period);
    assign elapsed_sum = esum[32] ? 32'hFFFF_FFFF : esum[31:0];

    // gains
    logic [8:0] kj, djg;
    always_comb begin
        kj  = '0;
        djg = '0;
        if (32'(jn) * 9 + 9 <= 63) begin
            kj  = 9'(stiff >> (6'(jn) * 6'd9));
            djg = 9'(damp  >> (6'(jn) * 6'd9));
        end
    end

    function automatic logic signed [63:0] rnd(input logic signed [63:0] n, input int sh);
        logic [63:0] mag;
        logic [63:0] q;
        mag = n[63] ? 64'(-n) : 64'(n);
        q   = (mag + (64'd1 << (sh - 1))) >> sh;
        return n[63] ? -$signed(q) : $signed(q);
    endfunction

    jimj_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (tnum_reg),
        .den    (dur_reg),
        .done   (div_done),
        .quot   (div_q)
    );

    assign cmd_ready = (state_reg == S_IDLE);
    assign div_start = (state_reg == S_DIVST);

    logic signed [63:0] tau_full;
    assign tau_full = rnd(64'(ktrm_reg) - 64'(dtrm_reg), 12);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            elapsed_reg  <= '0;
            safe_start_reg <= '0;
            tvalid_reg   <= 1'b0;
            first_reg    <= 1'b0;
            safe_reg     <= 1'b0;
            farp_reg     <= 1'b0;
            captured_reg <= 1'b0;
            out_valid    <= 1'b0;
            idx_reg      <= '0;
            for (int i = 0; i < JOINTS; i++) begin
                q_mem[i]  <= '0;
                v_mem[i]  <= '0;
                f_mem[i]  <= '0;
                st_mem[i] <= '0;
                tg_mem[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        idx_reg    <= '0;
                        maxerr_reg <= '0;
                        if (cmd.op == jimj_pkg::OP_TARGET) begin
                            stg_mem[cmd.joint] <= AW'(cmd.position);
                            if (cmd.closing) begin
                                for (int i = 0; i < JOINTS - 1; i++)
                                    tg_mem[i] <= stg_mem[i];
                                tg_mem[JOINTS-1] <= AW'(cmd.position);
                                state_reg <= S_TSCAN;
                            end
                        end else begin
                            q_mem[cmd.joint] <= AW'(cmd.position);
                            v_mem[cmd.joint] <= AW'(cmd.velocity);
                            if (cmd.closing) begin
                                elapsed_reg <= elapsed_sum;
                                state_reg   <= S_SSCAN;
                            end
                        end
                    end
                end
                S_TSCAN: begin
                    if (adj > maxerr_reg) maxerr_reg <= adj;
                    if (idx_reg == JW'(JOINTS - 1)) begin
                        tvalid_reg <= 1'b1;
                        farp_reg   <= ((adj > maxerr_reg) ? adj : maxerr_reg) > (AW+1)'(far_thr);
                        state_reg  <= S_IDLE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SSCAN: begin
                    if (!captured_reg) st_mem[idx_reg] <= qj;
                    if (adj > maxerr_reg) maxerr_reg <= adj;
                    if (idx_reg == JW'(JOINTS - 1)) begin
                        captured_reg <= 1'b1;
                        state_reg    <= S_DECIDE;
                        idx_reg      <= '0;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DECIDE: begin
                    state_reg <= S_JOINT;
                    mode_reg  <= jimj_pkg::MODE_DIRECT;
                    if (!tvalid_reg) begin
                        mode_reg <= jimj_pkg::MODE_HOLD;
                    end else if (32'(maxerr_reg) > 32'(far_thr)) begin
                        logic [31:0] ss, se;
                        logic        fresh;
                        // a new far target or a first far sample restarts the approach
                        fresh = !safe_reg || farp_reg;
                        ss    = fresh ? elapsed_reg : safe_start_reg;
                        se    = elapsed_reg - ss;
                        if (fresh) begin
                            for (int i = 0; i < JOINTS; i++) org_mem[i] <= q_mem[i];
                            safe_start_reg <= elapsed_reg;
                            farp_reg <= 1'b0;
                        end
                        if (32'(maxerr_reg) < 32'(jimj_pkg::CLOSE_LIMIT) ||
                            se >= 32'(safe_us)) begin
                            safe_reg  <= 1'b0;
                            first_reg <= 1'b1;
                        end else begin
                            safe_reg        <= 1'b1;
                            mode_reg        <= jimj_pkg::MODE_SAFE;
                            from_origin_reg <= 1'b1;
                            dur_reg         <= safe_us;
                            tnum_reg        <= se[23:0];
                            state_reg       <= S_DIVST;
                        end
                    end else begin
                        safe_reg <= 1'b0;
                        if (!first_reg) begin
                            if (elapsed_reg >= 32'(first_us) ||
                                32'(maxerr_reg) < 32'(jimj_pkg::CLOSE_LIMIT)) begin
                                first_reg <= 1'b1;
                            end else begin
                                mode_reg        <= jimj_pkg::MODE_FIRST;
                                from_origin_reg <= 1'b0;
                                dur_reg         <= first_us;
                                tnum_reg        <= elapsed_reg[23:0];
                                state_reg       <= S_DIVST;
                            end
                        end
                    end
                end
                S_DIVST: state_reg <= S_DIVWT;
                S_DIVWT: begin
                    if (div_done) begin
                        s_reg     <= div_q;
                        state_reg <= S_P1;
                    end
                end
                S_P1: begin
                    s2_reg    <= 17'((34'(s_reg) * 34'(s_reg)) >> 16);
                    state_reg <= S_P2;
                end
                S_P2: begin
                    s3_reg    <= 17'((34'(s2_reg) * 34'(s_reg)) >> 16);
                    inner_reg <= 20'(21'd655360 + 21'(s2_reg) * 21'd6 - 21'(s_reg) * 21'd15);
                    state_reg <= S_P3;
                end
                S_P3: begin
                    poly_reg  <= 32'((37'(s3_reg) * 37'(inner_reg)) >> 16);
                    state_reg <= S_JOINT;
                end
                S_JOINT: begin
                    // goal difference and filter product
                    unique case (mode_reg)
                        jimj_pkg::MODE_HOLD:   diff_reg <= '0;
                        jimj_pkg::MODE_DIRECT: diff_reg <= (AW+2)'(tj) - (AW+2)'(qj);
                        default:               diff_reg <= (AW+2)'(tj) - (AW+2)'(fromj);
                    endcase
                    fnew_reg <= AW'(rnd(64'(signed'(f_mem[idx_reg])) * 64'(jimj_pkg::FILT_OLD)
                               + 64'(signed'(v_mem[idx_reg])) * 64'(jimj_pkg::FILT_NEW), 16));
                    state_reg <= S_G1;
                end
                S_G1: begin
                    prod_reg  <= (AW+34)'($signed({1'b0, poly_reg})) * (AW+34)'(diff_reg);
                    f_mem[idx_reg] <= fnew_reg;
                    state_reg <= S_G2;
                end
                S_G2: begin
                    unique case (mode_reg)
                        jimj_pkg::MODE_HOLD, jimj_pkg::MODE_DIRECT:
                            goal_reg <= diff_reg;
                        default:
                            goal_reg <= (AW+2)'((AW+2)'(fromj) + (AW+2)'(rnd(64'(prod_reg), 16))
                                        - (AW+2)'(qj));
                    endcase
                    state_reg <= S_TQ1;
                end
                S_TQ1: begin
                    ktrm_reg  <= 48'(goal_reg) * 48'($signed({1'b0, kj})) * 48'sd16;
                    dtrm_reg  <= 48'(fnew_reg) * 48'($signed({1'b0, djg}));
                    state_reg <= S_TQ2;
                end
                S_TQ2: begin
                    if (tau_full > 64'sd8388607)       out_torque <= 24'h7FFFFF;
                    else if (tau_full < -64'sd8388608) out_torque <= 24'h800000;
                    else                               out_torque <= 24'(tau_full);
                    out_joint <= jn;
                    out_mode  <= mode_reg;
                    out_last  <= (idx_reg == JW'(JOINTS - 1));
                    out_valid <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_ready) begin
                        out_valid <= 1'b0;
                        if (idx_reg == JW'(JOINTS - 1)) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_JOINT;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule : jimj_back

`default_nettype wire

>>> sv/jimj_checker.sv
//------------------------------------------------------------------------------
// jimj_checker: port-level checks
// Output framing and stall behavior seen at the top-level ports.
//------------------------------------------------------------------------------
`default_nettype none

module jimj_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[2:0] == 3'd6)))
        else $error("tlast not on final joint");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd7)
        else $error("bad joint number");

endmodule : jimj_checker

bind joint_impedance_min_jerk_controller_core jimj_checker u_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
